// File: rtl/vlot_pkg.sv
// shared types, constants and the hash mix step of the voxel log-odds table
package vlot_pkg;

    localparam int COUNT_W = 13;
    localparam int VALUE_W = 16;
    localparam int EPOCH_W = 4;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;

    localparam logic [1:0] REQ_QUERY = 2'd0;
    localparam logic [1:0] REQ_MISS  = 2'd1;
    localparam logic [1:0] REQ_HIT   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [2:0] CFG_CAPACITY = 3'd0;
    localparam logic [2:0] CFG_HIT      = 3'd1;
    localparam logic [2:0] CFG_MISS     = 3'd2;
    localparam logic [2:0] CFG_FLOOR    = 3'd3;
    localparam logic [2:0] CFG_CEILING  = 3'd4;
    localparam logic [2:0] CFG_OCC      = 3'd5;
    localparam logic [2:0] CFG_FREE     = 3'd6;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] key_x;
        logic signed [15:0] key_y;
        logic signed [15:0] key_z;
    } req_t;

    typedef struct packed {
        logic signed [15:0]   log_odds;
        logic                 occupied;
        logic                 free_flag;
        logic                 dropped;
        logic                 inserted;
        logic [COUNT_W-1:0]   entry_count;
    } rsp_t;

    typedef struct packed {
        logic [COUNT_W-1:0] capacity_limit;
        logic signed [15:0] hit_delta;
        logic signed [15:0] miss_delta;
        logic signed [15:0] floor_log_odds;
        logic signed [15:0] ceiling_log_odds;
        logic signed [15:0] occupied_level;
        logic signed [15:0] free_level;
    } cfg_t;

    function automatic logic [63:0] hash_mix(input logic [63:0] seed, input logic [31:0] c);
        return seed ^ (64'(c) + GOLDEN + (seed << 6) + (seed >> 2));
    endfunction

endpackage

// File: rtl/vlot_mem.sv
// simple dual-port entry memory with registered read data
module vlot_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 68
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/vlot_update.sv
// saturating log-odds update and threshold flags
module vlot_update (
    input  vlot_pkg::cfg_t     cfg,
    input  logic               add_en,
    input  logic               is_hit,
    input  logic signed [15:0] base,
    output logic signed [15:0] value,
    output logic               occupied,
    output logic               free_flag
);

    logic signed [16:0] delta;
    logic signed [16:0] sum;
    logic signed [16:0] lo_clamped;
    logic signed [16:0] hi_clamped;

    always_comb
    begin
        delta = is_hit ? 17'(cfg.hit_delta) : 17'(cfg.miss_delta);
        sum = 17'(base) + delta;
        // floor first, then ceiling, so the ceiling wins on crossed bounds
        lo_clamped = (sum < 17'(cfg.floor_log_odds)) ? 17'(cfg.floor_log_odds) : sum;
        hi_clamped = (lo_clamped > 17'(cfg.ceiling_log_odds)) ?
                     17'(cfg.ceiling_log_odds) : lo_clamped;
        value = add_en ? 16'(hi_clamped) : base;
        occupied = (value >= cfg.occupied_level);
        free_flag = (value <= cfg.free_level);
    end

endmodule

// File: rtl/voxel_log_odds_table.sv
// top level of the voxel log-odds table: hash, probe, update and clear control
//
//  channel   | signals                         | transaction
//  ----------+---------------------------------+------------------------------------
//  request   | start, busy, req                | start high while busy is low
//  result    | result_valid, result            | one-cycle strobe, cannot be held off
//  config    | cfg_valid, cfg_ready, cfg_index,| cfg_valid and cfg_ready both high
//            | cfg_data                        | (cfg_ready is always high)
//
// a lookup or update goes from accept to result strobe through hash
// mixing (one 64-bit mix step per coordinate), p probe reads of the entry
// memory (one per cycle, p = probe chain length), the resolve state and the result
// register. a clear strobes its result on the next cycle; every 2^EPOCH_W - 1 clears
// it is followed by a sweep that zeroes every entry. after reset the same sweep
// runs with busy high. the result side has no stall.
module voxel_log_odds_table #(
    parameter int TABLE_SIZE = 4096,   // power of two
    parameter int COORD_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vlot_pkg::req_t   req,
    output logic             result_valid,
    output vlot_pkg::rsp_t   result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int CW     = vlot_pkg::COUNT_W;
    localparam int LIM_W  = (CNT_W > CW) ? CNT_W : CW;
    localparam int EW     = vlot_pkg::EPOCH_W;
    localparam int VW     = vlot_pkg::VALUE_W;
    localparam int KEY_W  = 3 * COORD_BITS;
    localparam int WORD_W = EW + KEY_W + VW;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SWEEP   = 5'b00010,
        ST_MIX     = 5'b00100,
        ST_PROBE   = 5'b01000,
        ST_RESOLVE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    vlot_pkg::req_t     req_reg, req_next;
    vlot_pkg::cfg_t     cfg_reg, cfg_next;
    logic [1:0]         mix_cnt_reg, mix_cnt_next;
    logic [63:0]        seed_reg, seed_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]   sweep_reg, sweep_next;
    logic [EW-1:0]      epoch_reg, epoch_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               found_reg, found_next;
    logic               empty_reg, empty_next;
    logic signed [15:0] old_val_reg, old_val_next;
    logic               out_valid_reg, out_valid_next;
    vlot_pkg::rsp_t     out_reg, out_next;

    // memory side
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;

    // coordinates cut or widened to COORD_BITS
    logic [COORD_BITS-1:0] cx, cy, cz, cmix;
    logic [KEY_W-1:0]      key;
    logic [31:0]           mix_word;
    logic [63:0]           seed_step;

    // probe decode
    logic [EW-1:0]      ent_epoch;
    logic [KEY_W-1:0]   ent_key;
    logic signed [15:0] ent_val;
    logic               ent_valid;
    logic               ent_match;

    // resolve
    logic [LIM_W-1:0]   cap_ext, tsz, limit;
    logic               at_limit;
    logic               is_update;
    logic               drop;
    logic signed [15:0] base;
    logic signed [15:0] new_val;
    logic               occ_flag;
    logic               free_f;

    vlot_mem #(
        .DEPTH (TABLE_SIZE),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    vlot_update u_update (
        .cfg       (cfg_reg),
        .add_en    (is_update && !drop),
        .is_hit    (req_reg.req_type == vlot_pkg::REQ_HIT),
        .base      (base),
        .value     (new_val),
        .occupied  (occ_flag),
        .free_flag (free_f)
    );

    assign cx  = COORD_BITS'($unsigned(req_reg.key_x));
    assign cy  = COORD_BITS'($unsigned(req_reg.key_y));
    assign cz  = COORD_BITS'($unsigned(req_reg.key_z));
    assign key = {cz, cy, cx};

    // one coordinate per mix cycle, sign-extended to 32 bits
    always_comb
    begin
        case (mix_cnt_reg)
            2'd0:    cmix = cx;
            2'd1:    cmix = cy;
            default: cmix = cz;
        endcase
        mix_word  = 32'($signed(cmix));
        seed_step = vlot_pkg::hash_mix(seed_reg, mix_word);
    end

    assign ent_epoch = rd_data[WORD_W-1 -: EW];
    assign ent_key   = rd_data[VW +: KEY_W];
    assign ent_val   = rd_data[VW-1:0];
    assign ent_valid = (ent_epoch == epoch_reg);
    assign ent_match = ent_valid && (ent_key == key);

    // capacity in effect: the register, or table size when zero, never above table size
    assign cap_ext  = LIM_W'(cfg_reg.capacity_limit);
    assign tsz      = LIM_W'(TABLE_SIZE);
    assign limit    = (cfg_reg.capacity_limit == '0) ? tsz : ((cap_ext > tsz) ? tsz : cap_ext);
    assign at_limit = (LIM_W'(total_reg) >= limit);

    assign is_update = (req_reg.req_type == vlot_pkg::REQ_MISS) ||
                       (req_reg.req_type == vlot_pkg::REQ_HIT);
    assign drop      = is_update && !found_reg && (at_limit || !empty_reg);
    assign base      = found_reg ? old_val_reg : 16'sd0;

    // configuration writes, accepted every cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                vlot_pkg::CFG_CAPACITY: cfg_next.capacity_limit   = cfg_data[CW-1:0];
                vlot_pkg::CFG_HIT:      cfg_next.hit_delta        = cfg_data;
                vlot_pkg::CFG_MISS:     cfg_next.miss_delta       = cfg_data;
                vlot_pkg::CFG_FLOOR:    cfg_next.floor_log_odds   = cfg_data;
                vlot_pkg::CFG_CEILING:  cfg_next.ceiling_log_odds = cfg_data;
                vlot_pkg::CFG_OCC:      cfg_next.occupied_level   = cfg_data;
                vlot_pkg::CFG_FREE:     cfg_next.free_level       = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        mix_cnt_next   = mix_cnt_reg;
        seed_next      = seed_reg;
        addr_next      = addr_reg;
        probe_cnt_next = probe_cnt_reg;
        sweep_next     = sweep_reg;
        epoch_next     = epoch_reg;
        total_next     = total_reg;
        found_next     = found_reg;
        empty_next     = empty_reg;
        old_val_next   = old_val_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = {epoch_reg, key, new_val};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.req_type == vlot_pkg::REQ_CLEAR)
                    begin
                        // clear: retire the epoch, or sweep when epochs run out
                        total_next     = '0;
                        out_valid_next = 1'b1;
                        out_next       = '0;
                        if (epoch_reg == '1)
                        begin
                            sweep_next = '0;
                            state_next = ST_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        seed_next    = '0;
                        mix_cnt_next = '0;
                        state_next   = ST_MIX;
                    end
                end
            end

            ST_SWEEP:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = '0;
                sweep_next = sweep_reg + 1'b1;
                epoch_next = EW'(1);
                if (sweep_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_MIX:
            begin
                seed_next    = seed_step;
                mix_cnt_next = mix_cnt_reg + 1'b1;
                if (mix_cnt_reg == 2'd2)
                begin
                    // home slot is the hash modulo table size
                    rd_en          = 1'b1;
                    rd_addr        = seed_step[IDX_W-1:0];
                    addr_next      = seed_step[IDX_W-1:0];
                    probe_cnt_next = '0;
                    state_next     = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                if (!ent_valid || ent_match || probe_cnt_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    found_next   = ent_match;
                    empty_next   = !ent_valid;
                    old_val_next = ent_val;
                    state_next   = ST_RESOLVE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = addr_reg + 1'b1;
                    addr_next      = addr_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end

            ST_RESOLVE:
            begin
                if (is_update && !drop)
                begin
                    wr_en = 1'b1;
                    if (!found_reg)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                out_valid_next       = 1'b1;
                out_next.log_odds    = new_val;
                out_next.occupied    = occ_flag;
                out_next.free_flag   = free_f;
                out_next.dropped     = drop;
                out_next.inserted    = is_update && !drop && !found_reg;
                out_next.entry_count = CW'(total_next);
                state_next           = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            epoch_reg     <= EW'(1);
            total_reg     <= '0;
            mix_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            cfg_reg.capacity_limit   <= '0;
            cfg_reg.hit_delta        <= 16'sd218;
            cfg_reg.miss_delta       <= -16'sd102;
            cfg_reg.floor_log_odds   <= -16'sd512;
            cfg_reg.ceiling_log_odds <= 16'sd896;
            cfg_reg.occupied_level   <= 16'sd128;
            cfg_reg.free_level       <= -16'sd128;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            epoch_reg     <= epoch_next;
            total_reg     <= total_next;
            mix_cnt_reg   <= mix_cnt_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        seed_reg      <= seed_next;
        addr_reg      <= addr_next;
        probe_cnt_reg <= probe_cnt_next;
        found_reg     <= found_next;
        empty_reg     <= empty_next;
        old_val_reg   <= old_val_next;
        out_reg       <= out_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: sim/tb_top.sv
// testbench for the voxel log-odds table: directed and random requests checked by a predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS = 4096;
    // a generous wait after the last result
    localparam int SETTLE = 64;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    vlot_pkg::req_t req = '0;
    logic           result_valid;
    vlot_pkg::rsp_t result;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [2:0]     cfg_index = '0;
    logic [15:0]    cfg_data = '0;

    voxel_log_odds_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // shadow copy of the table and its settings
    logic               slot_used [SLOTS];
    logic [47:0]        slot_key [SLOTS];
    logic signed [15:0] slot_val [SLOTS];
    int unsigned        held;
    logic [12:0]        cap_lim;
    logic signed [15:0] hit_d, miss_d, lo_bound, hi_bound, occ_lvl, free_lvl;

    vlot_pkg::rsp_t pending[$];
    int             errors = 0;
    bit             idle_on = 1'b1;
    vlot_pkg::req_t key_pool[$];

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [63:0] mix_step(input logic [63:0] seed,
                                             input logic signed [15:0] c);
        logic [63:0] u;
        u = {32'b0, 32'(signed'(c))};
        return seed ^ (u + 64'h9e3779b97f4a7c15 + (seed << 6) + (seed >> 2));
    endfunction

    function automatic vlot_pkg::rsp_t flags_for(input logic signed [15:0] v);
        vlot_pkg::rsp_t r;
        r = '0;
        r.log_odds  = v;
        r.occupied  = (v >= occ_lvl);
        r.free_flag = (v <= free_lvl);
        return r;
    endfunction

    // compute the table's answer to one request and apply its effect
    function automatic vlot_pkg::rsp_t predict_voxel(input vlot_pkg::req_t q);
        vlot_pkg::rsp_t     r;
        logic [63:0]        h;
        logic [47:0]        k;
        int unsigned        idx, lim;
        bit                 found, empty;
        logic signed [31:0] sum;
        r = '0;
        found = 0;
        empty = 0;
        if (q.req_type == vlot_pkg::REQ_CLEAR)
        begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            held = 0;
            return r;
        end
        k = {q.key_z, q.key_y, q.key_x};
        h = mix_step(mix_step(mix_step(64'd0, q.key_x), q.key_y), q.key_z);
        idx = 32'(h[11:0]);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!slot_used[idx])
            begin
                empty = 1;
                break;
            end
            if (slot_key[idx] == k)
            begin
                found = 1;
                break;
            end
            idx = (idx + 1) % SLOTS;
        end
        if (q.req_type == vlot_pkg::REQ_QUERY)
        begin
            r = flags_for(found ? slot_val[idx] : 16'sd0);
            r.entry_count = 13'(held);
            return r;
        end
        if (!found)
        begin
            lim = (cap_lim == 13'd0) ? SLOTS : 32'(cap_lim);
            if (lim > SLOTS) lim = SLOTS;
            if (held >= lim || !empty)
            begin
                r = flags_for(16'sd0);
                r.dropped = 1'b1;
                r.entry_count = 13'(held);
                return r;
            end
            slot_used[idx] = 1'b1;
            slot_key[idx] = k;
            slot_val[idx] = '0;
            held++;
        end
        sum = 32'(slot_val[idx]) + 32'((q.req_type == vlot_pkg::REQ_HIT) ? hit_d : miss_d);
        if (sum < 32'(lo_bound)) sum = 32'(lo_bound);
        if (sum > 32'(hi_bound)) sum = 32'(hi_bound);
        slot_val[idx] = sum[15:0];
        r = flags_for(sum[15:0]);
        r.inserted = !found;
        r.entry_count = 13'(held);
        return r;
    endfunction

    // result checker: every strobe against the oldest expectation
    always @(posedge clk)
    begin
        vlot_pkg::rsp_t e;
        if (rst_n && result_valid)
        begin
            if (pending.size() == 0)
            begin
                report("result with nothing expected");
            end
            else
            begin
                e = pending.pop_front();
                if (result.log_odds !== e.log_odds)
                    report($sformatf("log_odds %0d exp %0d", result.log_odds, e.log_odds));
                if (result.occupied !== e.occupied)
                    report($sformatf("occupied %b exp %b", result.occupied, e.occupied));
                if (result.free_flag !== e.free_flag)
                    report($sformatf("free_flag %b exp %b", result.free_flag, e.free_flag));
                if (result.dropped !== e.dropped)
                    report($sformatf("dropped %b exp %b", result.dropped, e.dropped));
                if (result.inserted !== e.inserted)
                    report($sformatf("inserted %b exp %b", result.inserted, e.inserted));
                if (result.entry_count !== e.entry_count)
                    report($sformatf("entry_count %0d exp %0d", result.entry_count,
                                     e.entry_count));
            end
        end
    end

    // one request transaction; start stays high straight into the next one if no gap
    task automatic send_req(input vlot_pkg::req_t q);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 17)) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        req = q;
        do @(posedge clk); while (busy);
        pending = {pending, predict_voxel(q)};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // register write transaction; only called once the table is drained
    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            vlot_pkg::CFG_CAPACITY: cap_lim  = data[12:0];
            vlot_pkg::CFG_HIT:      hit_d    = data;
            vlot_pkg::CFG_MISS:     miss_d   = data;
            vlot_pkg::CFG_FLOOR:    lo_bound = data;
            vlot_pkg::CFG_CEILING:  hi_bound = data;
            vlot_pkg::CFG_OCC:      occ_lvl  = data;
            vlot_pkg::CFG_FREE:     free_lvl = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_all(input logic [15:0] cap, input logic [15:0] hd, input logic [15:0] md,
                           input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] oc, input logic [15:0] fr);
        wait_drained();
        write_reg(vlot_pkg::CFG_CAPACITY, cap);
        write_reg(vlot_pkg::CFG_HIT, hd);
        write_reg(vlot_pkg::CFG_MISS, md);
        write_reg(vlot_pkg::CFG_FLOOR, lo);
        write_reg(vlot_pkg::CFG_CEILING, hi);
        write_reg(vlot_pkg::CFG_OCC, oc);
        write_reg(vlot_pkg::CFG_FREE, fr);
    endtask

    function automatic vlot_pkg::req_t mk(input logic [1:0] t, input int x, input int y,
                                          input int z);
        vlot_pkg::req_t q;
        q.req_type = t;
        q.key_x = 16'(x);
        q.key_y = 16'(y);
        q.key_z = 16'(z);
        return q;
    endfunction

    // absent keys, coordinate extremes, every request type, saturation and clear
    task automatic test_directed();
        send_req(mk(vlot_pkg::REQ_QUERY, 0, 0, 0));
        send_req(mk(vlot_pkg::REQ_HIT, 0, 0, 0));
        send_req(mk(vlot_pkg::REQ_HIT, 0, 0, 0));
        send_req(mk(vlot_pkg::REQ_MISS, 0, 0, 0));
        send_req(mk(vlot_pkg::REQ_QUERY, 0, 0, 0));
        send_req(mk(vlot_pkg::REQ_HIT, -32768, 32767, -1));
        send_req(mk(vlot_pkg::REQ_MISS, 32767, -32768, 0));
        send_req(mk(vlot_pkg::REQ_MISS, -1, -1, -1));
        repeat (6) send_req(mk(vlot_pkg::REQ_HIT, 5, 5, 5));    // drive into the ceiling
        repeat (7) send_req(mk(vlot_pkg::REQ_MISS, 6, 6, 6));   // drive into the floor
        send_req(mk(vlot_pkg::REQ_QUERY, -32768, 32767, -1));
        send_req(mk(vlot_pkg::REQ_CLEAR, 1234, -77, 9));
        send_req(mk(vlot_pkg::REQ_QUERY, 5, 5, 5));
    endtask

    // small capacity: new keys get dropped while existing ones still update
    task automatic test_capacity();
        set_all(16'd3, 16'sd100, -16'sd50, -16'sd300, 16'sd300, 16'sd0, 16'sd0);
        for (int i = 0; i < 5; i++) send_req(mk(vlot_pkg::REQ_HIT, i, -i, 2 * i));
        send_req(mk(vlot_pkg::REQ_MISS, 1, -1, 2));
        send_req(mk(vlot_pkg::REQ_QUERY, 4, -4, 8));
        send_req(mk(vlot_pkg::REQ_CLEAR, 0, 0, 0));
        send_req(mk(vlot_pkg::REQ_HIT, 4, -4, 8));
    endtask

    // floor above ceiling: the ceiling wins
    task automatic test_crossed_bounds();
        set_all(16'd0, 16'sd10, -16'sd10, 16'sd400, -16'sd400, 16'sd0, -16'sd1);
        send_req(mk(vlot_pkg::REQ_HIT, 7, 8, 9));
        send_req(mk(vlot_pkg::REQ_MISS, 7, 8, 9));
        send_req(mk(vlot_pkg::REQ_QUERY, 7, 8, 9));
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return 16'(int'($urandom_range(0, 15)) - 8);
            1: return 16'($urandom);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_phase(input int count);
        vlot_pkg::req_t q;
        for (int n = 0; n < count; n++)
        begin
            if (key_pool.size() == 0 || $urandom_range(0, 99) < 20)
            begin
                q = mk(vlot_pkg::REQ_QUERY, int'(pick_coord()), int'(pick_coord()),
                       int'(pick_coord()));
                key_pool = {key_pool, q};
                if (key_pool.size() > 60) void'(key_pool.pop_front());
            end
            else
            begin
                q = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            case ($urandom_range(0, 99)) inside
                [0:24]:  q.req_type = vlot_pkg::REQ_QUERY;
                [25:59]: q.req_type = vlot_pkg::REQ_MISS;
                [60:97]: q.req_type = vlot_pkg::REQ_HIT;
                default: q.req_type = vlot_pkg::REQ_CLEAR;
            endcase
            send_req(q);
        end
    endtask

    // random items under a sequence of settings, the extremes among them
    task automatic test_random();
        set_all(16'd0, 16'sd218, -16'sd102, -16'sd512, 16'sd896, 16'sd128, -16'sd128);
        random_phase(300);
        set_all(16'hffff, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                16'sd32767, -16'sd32768);
        random_phase(250);
        set_all(16'd4096, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                -16'sd32768, 16'sd32767);
        random_phase(250);
        set_all(16'd20, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
        random_phase(250);
        set_all(16'($urandom_range(1, 8191)), 16'(int'($urandom_range(0, 2000)) - 1000),
                16'(int'($urandom_range(0, 2000)) - 1000), -16'sd3000, 16'sd3000,
                16'(int'($urandom_range(0, 600)) - 300),
                16'(int'($urandom_range(0, 600)) - 300));
        random_phase(250);
        set_all(16'd0, 16'sd218, -16'sd102, -16'sd512, 16'sd896, 16'sd128, -16'sd128);
        idle_on = 1'b0;                                // no gaps in the last part
        random_phase(300);
    endtask

    initial
    begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        held = 0;
        cap_lim = 0; hit_d = 218; miss_d = -102; lo_bound = -512; hi_bound = 896;
        occ_lvl = 128; free_lvl = -128;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_capacity();
        test_crossed_bounds();
        test_random();
        wait_drained();
        if (errors == 0 && pending.size() == 0)
            $display("** voxel_log_odds_table: PASSED **");
        else
            $display("** voxel_log_odds_table: FAILED **");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("** voxel_log_odds_table: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/vlot_pkg.sv
rtl/vlot_mem.sv
rtl/vlot_update.sv
rtl/voxel_log_odds_table.sv
sim/tb_top.sv
